/* hdl/encoder_speed_controller_assert.svh */
// Assertion macros for the encoder speed controller; clk and rst come from the using module.
`ifndef ENCODER_SPEED_CONTROLLER_ASSERT_SVH
`define ENCODER_SPEED_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define ESC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ESC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/esc_pkg.sv */
// Package: types, constants and reset values of the encoder speed controller.
`timescale 1ns / 1ps

package esc_pkg;

  localparam int WHEELS       = 4;
  localparam int TICK_RESULTS = (WHEELS < 4) ? WHEELS : 4;
  localparam int WHEEL_AW     = (WHEELS > 1) ? $clog2(WHEELS) : 1;
  localparam int IDX_W        = (TICK_RESULTS > 1) ? $clog2(TICK_RESULTS) : 1;
  localparam int SIDES        = 2;

  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [19:0]        US_PER_S      = 20'd1000000;
  localparam logic signed [12:0] ERR_LIMIT_Q16 = 13'sd3277;

  localparam logic [9:0]  RST_STEP_SIZE          = 10'd10;
  localparam logic [7:0]  RST_GEAR_RATIO         = 8'd1;
  localparam logic [15:0] RST_MAX_WHEEL_TARGET   = 16'd65535;
  localparam logic [15:0] RST_MAX_ENCODER_TARGET = 16'd65535;
  localparam logic [17:0] RST_MAX_DRIVE_Q16      = 18'd216269;
  localparam logic [15:0] RST_RPM_PER_HZ_Q8      = 16'd15360;
  localparam logic [7:0]  RST_DUTY_SCALE         = 8'd77;

  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  typedef enum logic [1:0] {
    FUNC_EDGE   = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_ADJUST = 2'd2,
    FUNC_SET    = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_SIZE          = 3'd0,
    REG_GEAR_RATIO         = 3'd1,
    REG_MAX_WHEEL_TARGET   = 3'd2,
    REG_MAX_ENCODER_TARGET = 3'd3,
    REG_MAX_DRIVE_Q16      = 3'd4,
    REG_RPM_PER_HZ_Q8      = 3'd5,
    REG_DUTY_SCALE         = 3'd6
  } cfg_reg_t;

  // Per-wheel memory entry.
  typedef struct packed {
    logic [31:0] period;
    logic [31:0] last_edge;
    logic [17:0] drive;
  } wheel_ent_t;

  // Per-side memory entry.
  typedef struct packed {
    logic [15:0] wheel_target;
    logic [15:0] encoder_target;
  } tgt_ent_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* hdl/esc_if.sv */
// Interfaces: command channel and result channel of the encoder speed controller.
`timescale 1ns / 1ps

interface esc_cmd_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [1:0]        wheel;
  logic [31:0]       edge_time;
  logic              side_sel;
  logic signed [7:0] amount;
  logic [15:0]       target_rpm;

  modport source (output valid, func, wheel, edge_time, side_sel, amount, target_rpm,
                  input ready);
  modport sink (input valid, func, wheel, edge_time, side_sel, amount, target_rpm,
                output ready);
endinterface

interface esc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_wheel;
  logic [7:0]  duty;
  logic [15:0] measured_rpm;
  logic        last;

  modport source (output valid, out_wheel, duty, measured_rpm, last, input ready);
  modport sink (input valid, out_wheel, duty, measured_rpm, last, output ready);
endinterface

/* hdl/esc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module esc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/esc_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module esc_div
  import esc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     dvs;
  logic [DIV_W:0]       shifted;
  logic [DIV_W:0]       trial;

  assign shifted = {rem, quo[DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W - 1);
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        if (!trial[DIV_W]) begin
          rem <= trial[DIV_W-1:0];
          quo <= {quo[DIV_W-2:0], 1'b1};
        end else begin
          rem <= shifted[DIV_W-1:0];
          quo <= {quo[DIV_W-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - DIV_CNT_W'(1);
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* hdl/encoder_speed_controller.sv */
// Top level: four-wheel encoder speed controller with per-wheel and per-side state memories.
//
// Commands arrive on cmd (valid/ready); a transaction is taken when both are high.
// func selects an encoder edge, a control tick, a target adjust or a target set.
// Edge, adjust and set produce no results; a tick produces one result per wheel
// on result (valid/ready), wheels in order, with last set on the final one.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must write them only
// while the block is idle, which the block itself leaves unchecked. Per-wheel state
// (period, last edge time, drive) sits in one RAM, per-side targets in another; each item
// is a read, a modify and a write-back, one item at a time. A tick uses the shared
// divider up to twice per wheel (rpm from period, then relative error).
// cmd.ready is high only while idle. A stalled result holds the tick at its output
// step; the last result sits in the output register while new commands are taken.
// Reset (rst, synchronous) clears the memories' valid bits so all state reads as
// zero, and loads register defaults.
`timescale 1ns / 1ps
`include "encoder_speed_controller_assert.svh"

module encoder_speed_controller
  import esc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  esc_cmd_if.sink               cmd,
  esc_res_if.source             result
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_EDGE_RD,
    S_EDGE_WR,
    S_ADJ_RD,
    S_ADJ_MUL,
    S_ADJ_SUM,
    S_ADJ_WR,
    S_SET_RD,
    S_SET_WR,
    S_TICK_RD,
    S_TICK_LOAD,
    S_TICK_RPM,
    S_RPM_WAIT,
    S_TICK_ERR,
    S_ERR_WAIT,
    S_TICK_DRIVE,
    S_TICK_WR,
    S_TICK_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [9:0]  step_size;
  logic [7:0]  gear_ratio;
  logic [15:0] max_wheel_target;
  logic [15:0] max_encoder_target;
  logic [17:0] max_drive_q16;
  logic [15:0] rpm_per_hz_q8;
  logic [7:0]  duty_scale;

  // Latched command.
  func_t             func_q;
  logic [1:0]        wheel_q;
  logic [31:0]       edge_time_q;
  logic              side_q;
  logic signed [7:0] amount_q;
  logic [15:0]       target_rpm_q;

  // Working registers.
  logic [IDX_W-1:0]   idx;
  logic [31:0]        period;
  logic [31:0]        last_edge;
  logic [17:0]        drive;
  logic [15:0]        tgt;
  logic [15:0]        wt;
  logic signed [18:0] adj_prod;
  logic [27:0]        num;
  logic [15:0]        rpm;
  logic signed [12:0] err;
  logic [25:0]        duty_prod;

  // Output register.
  logic        res_valid;
  logic [1:0]  res_wheel;
  logic [7:0]  res_duty;
  logic [15:0] res_rpm;
  logic        res_last;

  // Memory valid bits.
  logic [WHEELS-1:0] wheel_vld;
  logic [SIDES-1:0]  tgt_vld;
  logic              wheel_rd_vld;
  logic              tgt_rd_vld;

  // Memory ports.
  logic [WHEEL_AW-1:0]       wheel_addr;
  logic                      wheel_we;
  wheel_ent_t                wheel_wdata;
  logic [$bits(wheel_ent_t)-1:0] wheel_rdata;
  wheel_ent_t                wheel_rd;
  logic                      tick_side;
  logic                      tgt_addr;
  logic                      tgt_we;
  tgt_ent_t                  tgt_wdata;
  logic [$bits(tgt_ent_t)-1:0] tgt_rdata;
  tgt_ent_t                  tgt_rd;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Datapath.
  logic signed [18:0] adj_mult;
  logic signed [19:0] adj_sum;
  logic [15:0]        adj_clamped;
  logic [15:0]        gear_src;
  logic [23:0]        enc_prod;
  logic [15:0]        enc_clamped;
  logic [35:0]        num_mult;
  logic [15:0]        rpm_sat;
  logic signed [16:0] diff;
  logic signed [21:0] diff20;
  logic signed [21:0] tgt_ext;
  logic               err_hi;
  logic               err_lo;
  logic [15:0]        abs_diff;
  logic signed [12:0] err_div;
  logic signed [19:0] drive_sum;
  logic [17:0]        drive_clamped;
  logic [25:0]        duty_mult;
  logic [7:0]         duty_sat;
  logic               is_last;
  logic               edge_ok;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size          <= RST_STEP_SIZE;
      gear_ratio         <= RST_GEAR_RATIO;
      max_wheel_target   <= RST_MAX_WHEEL_TARGET;
      max_encoder_target <= RST_MAX_ENCODER_TARGET;
      max_drive_q16      <= RST_MAX_DRIVE_Q16;
      rpm_per_hz_q8      <= RST_RPM_PER_HZ_Q8;
      duty_scale         <= RST_DUTY_SCALE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_SIZE:          step_size          <= cfg_data[9:0];
        REG_GEAR_RATIO:         gear_ratio         <= cfg_data[7:0];
        REG_MAX_WHEEL_TARGET:   max_wheel_target   <= cfg_data[15:0];
        REG_MAX_ENCODER_TARGET: max_encoder_target <= cfg_data[15:0];
        REG_MAX_DRIVE_Q16:      max_drive_q16      <= cfg_data[17:0];
        REG_RPM_PER_HZ_Q8:      rpm_per_hz_q8      <= cfg_data[15:0];
        REG_DUTY_SCALE:         duty_scale         <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Memory addressing and write-back.
  assign tick_side  = ((idx == IDX_W'(0)) || (idx == IDX_W'(1))) ? SIDE_RIGHT : SIDE_LEFT;
  assign wheel_addr = (func_q == FUNC_TICK) ? WHEEL_AW'(idx) : WHEEL_AW'(wheel_q);
  assign tgt_addr   = (func_q == FUNC_TICK) ? tick_side : side_q;

  assign wheel_rd = wheel_rd_vld ? wheel_ent_t'(wheel_rdata) : '0;
  assign tgt_rd   = tgt_rd_vld ? tgt_ent_t'(tgt_rdata) : '0;

  assign wheel_we = (state == S_EDGE_WR) || (state == S_TICK_WR);
  assign tgt_we   = (state == S_ADJ_WR) || (state == S_SET_WR);

  always_comb begin
    if (state == S_EDGE_WR) begin
      wheel_wdata.period    = edge_time_q - wheel_rd.last_edge;
      wheel_wdata.last_edge = edge_time_q;
      wheel_wdata.drive     = wheel_rd.drive;
    end else begin
      wheel_wdata.period    = period;
      wheel_wdata.last_edge = last_edge;
      wheel_wdata.drive     = drive;
    end
  end

  assign gear_src    = (state == S_ADJ_WR) ? wt : target_rpm_q;
  assign enc_prod    = gear_src * gear_ratio;
  assign enc_clamped = (enc_prod > {8'd0, max_encoder_target}) ? max_encoder_target
                                                              : enc_prod[15:0];

  always_comb begin
    tgt_wdata.wheel_target   = (state == S_ADJ_WR) ? wt : tgt_rd.wheel_target;
    tgt_wdata.encoder_target = enc_clamped;
  end

  esc_ram #(
    .WIDTH($bits(wheel_ent_t)),
    .DEPTH(WHEELS)
  ) u_wheel_ram (
    .clk  (clk),
    .we   (wheel_we),
    .waddr(wheel_addr),
    .wdata(wheel_wdata),
    .raddr(wheel_addr),
    .rdata(wheel_rdata)
  );

  esc_ram #(
    .WIDTH($bits(tgt_ent_t)),
    .DEPTH(SIDES)
  ) u_tgt_ram (
    .clk  (clk),
    .we   (tgt_we),
    .waddr(tgt_addr),
    .wdata(tgt_wdata),
    .raddr(tgt_addr),
    .rdata(tgt_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_rd_vld <= 1'b0;
      tgt_rd_vld   <= 1'b0;
    end else begin
      wheel_rd_vld <= wheel_vld[wheel_addr];
      tgt_rd_vld   <= tgt_vld[tgt_addr];
    end
  end

  // Adjust arithmetic.
  assign adj_mult = $signed({1'b0, step_size}) * amount_q;
  assign adj_sum  = $signed({4'd0, wt}) + $signed({adj_prod[18], adj_prod});
  always_comb begin
    if (adj_sum[19]) begin
      adj_clamped = '0;
    end else if (adj_sum[18:0] > {3'd0, max_wheel_target}) begin
      adj_clamped = max_wheel_target;
    end else begin
      adj_clamped = adj_sum[15:0];
    end
  end

  // Speed and error arithmetic.
  assign num_mult = US_PER_S * rpm_per_hz_q8;
  assign rpm_sat  = (div_rsp.quotient[31:16] != '0) ? 16'hFFFF : div_rsp.quotient[15:0];
  assign diff     = $signed({1'b0, tgt}) - $signed({1'b0, rpm});
  assign diff20   = {{5{diff[16]}}, diff} * 22'sd20;
  assign tgt_ext  = $signed({6'd0, tgt});
  assign err_hi   = diff20 >= tgt_ext;
  assign err_lo   = (-diff20) >= tgt_ext;
  assign abs_diff = diff[16] ? 16'(-diff) : diff[15:0];
  assign err_div  = diff[16] ? -$signed(div_rsp.quotient[12:0])
                             : $signed(div_rsp.quotient[12:0]);

  assign drive_sum = $signed({2'd0, drive}) + $signed({{7{err[12]}}, err});
  always_comb begin
    if (drive_sum[19]) begin
      drive_clamped = '0;
    end else if (drive_sum[18:0] > {1'b0, max_drive_q16}) begin
      drive_clamped = max_drive_q16;
    end else begin
      drive_clamped = drive_sum[17:0];
    end
  end

  assign duty_mult = drive * duty_scale;
  assign duty_sat  = (duty_prod[25:16] > 10'd255) ? 8'd255 : duty_prod[23:16];
  assign is_last   = (idx == IDX_W'(TICK_RESULTS - 1));
  assign edge_ok   = int'(cmd.wheel) < WHEELS;

  // Divider requests.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {4'd0, num};
    div_req.divisor  = period;
    if (state == S_TICK_RPM) begin
      div_req.start = (period != '0);
    end else if (state == S_TICK_ERR) begin
      div_req.start    = (tgt != '0) && !err_hi && !err_lo;
      div_req.dividend = {abs_diff, 16'd0};
      div_req.divisor  = {16'd0, tgt};
    end
  end

  esc_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      res_valid <= 1'b0;
      wheel_vld <= '0;
      tgt_vld   <= '0;
    end else begin
      if (result.ready) begin
        res_valid <= 1'b0;
      end
      if (wheel_we) begin
        wheel_vld[wheel_addr] <= 1'b1;
      end
      if (tgt_we) begin
        tgt_vld[tgt_addr] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            func_q       <= func_t'(cmd.func);
            wheel_q      <= cmd.wheel;
            edge_time_q  <= cmd.edge_time;
            side_q       <= cmd.side_sel;
            amount_q     <= cmd.amount;
            target_rpm_q <= cmd.target_rpm;
            idx          <= '0;
            unique case (func_t'(cmd.func))
              FUNC_EDGE:   state <= edge_ok ? S_EDGE_RD : S_IDLE;
              FUNC_TICK:   state <= S_TICK_RD;
              FUNC_ADJUST: state <= S_ADJ_RD;
              FUNC_SET:    state <= S_SET_RD;
              default:     state <= S_IDLE;
            endcase
          end
        end
        S_EDGE_RD: state <= S_EDGE_WR;
        S_EDGE_WR: state <= S_IDLE;
        S_ADJ_RD:  state <= S_ADJ_MUL;
        S_ADJ_MUL: begin
          wt       <= tgt_rd.wheel_target;
          adj_prod <= adj_mult;
          state    <= S_ADJ_SUM;
        end
        S_ADJ_SUM: begin
          wt    <= adj_clamped;
          state <= S_ADJ_WR;
        end
        S_ADJ_WR:  state <= S_IDLE;
        S_SET_RD:  state <= S_SET_WR;
        S_SET_WR:  state <= S_IDLE;
        S_TICK_RD: state <= S_TICK_LOAD;
        S_TICK_LOAD: begin
          period    <= wheel_rd.period;
          last_edge <= wheel_rd.last_edge;
          drive     <= wheel_rd.drive;
          tgt       <= tgt_rd.encoder_target;
          num       <= num_mult[35:8];
          state     <= S_TICK_RPM;
        end
        S_TICK_RPM: begin
          if (period == '0) begin
            rpm   <= '0;
            state <= S_TICK_ERR;
          end else begin
            state <= S_RPM_WAIT;
          end
        end
        S_RPM_WAIT: begin
          if (div_rsp.done) begin
            rpm   <= rpm_sat;
            state <= S_TICK_ERR;
          end
        end
        S_TICK_ERR: begin
          if (tgt == '0) begin
            drive <= '0;
            state <= S_TICK_WR;
          end else if (err_hi) begin
            err   <= ERR_LIMIT_Q16;
            state <= S_TICK_DRIVE;
          end else if (err_lo) begin
            err   <= -ERR_LIMIT_Q16;
            state <= S_TICK_DRIVE;
          end else begin
            state <= S_ERR_WAIT;
          end
        end
        S_ERR_WAIT: begin
          if (div_rsp.done) begin
            err   <= err_div;
            state <= S_TICK_DRIVE;
          end
        end
        S_TICK_DRIVE: begin
          drive <= drive_clamped;
          state <= S_TICK_WR;
        end
        S_TICK_WR: begin
          duty_prod <= duty_mult;
          state     <= S_TICK_OUT;
        end
        S_TICK_OUT: begin
          if (!res_valid || result.ready) begin
            res_valid <= 1'b1;
            res_wheel <= 2'(idx);
            res_duty  <= duty_sat;
            res_rpm   <= rpm;
            res_last  <= is_last;
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_TICK_RD;
            end
          end
        end
      endcase
    end
  end

  assign cmd.ready           = (state == S_IDLE);
  assign result.valid        = res_valid;
  assign result.out_wheel    = res_wheel;
  assign result.duty         = res_duty;
  assign result.measured_rpm = res_rpm;
  assign result.last         = res_last;

  `ESC_ASSERT_IMP(a_idle_div_free, cmd.ready, !div_rsp.busy, "command taken while divider busy")
  `ESC_ASSERT_IMP(a_last_wheel, result.valid && result.last,
                  result.out_wheel == 2'(TICK_RESULTS - 1), "last flag on wrong wheel")
  `ESC_ASSERT_NXT(a_out_load, (state == S_TICK_OUT) && !res_valid, res_valid,
                  "free output register not loaded")
  `ESC_ASSERT_IMP(a_drive_clamp, state == S_TICK_WR, drive <= max_drive_q16,
                  "drive written above clamp")

endmodule

/* sim/encoder_speed_controller_tb.sv */
`timescale 1ns / 1ps
// Testbench for the encoder speed controller: directed table, then random phases against a Q16 predictor.
module encoder_speed_controller_tb;
  import esc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int SETTLE = 24;
  localparam int MAX_SHOWN = 10;
  localparam int PHASE_ITEMS = 44;
  localparam int PHASES = 6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    func_t             func;
    logic [1:0]        wheel;
    logic [31:0]       edge_time;
    logic              side_sel;
    logic signed [7:0] amount;
    logic [15:0]       target_rpm;
    logic              pinned;
    logic [7:0]        pin_duty;
    logic [15:0]       pin_rpm;
  } esc_cmd_t;

  typedef struct packed {
    logic [1:0]  out_wheel;
    logic [7:0]  duty;
    logic [15:0] measured_rpm;
    logic        last;
  } wheel_report_t;

  typedef logic [6:0][CFG_DATA_W-1:0] reg_set_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  calm = 1'b0;
  esc_cmd_t              on_wire;
  int unsigned           cycles = 0;
  int unsigned           faults = 0;
  wheel_report_t         due_reports [$];

  // predicted controller state
  logic [31:0] period_q [WHEELS];
  logic [31:0] last_edge_q [WHEELS];
  logic [17:0] drive_q [WHEELS];
  logic [15:0] wheel_tgt [SIDES];
  logic [15:0] enc_tgt [SIDES];
  logic [9:0]  step_r;
  logic [7:0]  gear_r;
  logic [15:0] maxw_r;
  logic [15:0] maxe_r;
  logic [17:0] maxd_r;
  logic [15:0] rphz_r;
  logic [7:0]  scale_r;

  esc_cmd_if cmd ();
  esc_res_if result ();

  encoder_speed_controller DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .result    (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void controller_reset();
    step_r  = RST_STEP_SIZE;
    gear_r  = RST_GEAR_RATIO;
    maxw_r  = RST_MAX_WHEEL_TARGET;
    maxe_r  = RST_MAX_ENCODER_TARGET;
    maxd_r  = RST_MAX_DRIVE_Q16;
    rphz_r  = RST_RPM_PER_HZ_Q8;
    scale_r = RST_DUTY_SCALE;
    for (int i = 0; i < WHEELS; i++) begin
      period_q[i] = '0;
      last_edge_q[i] = '0;
      drive_q[i] = '0;
    end
    for (int i = 0; i < SIDES; i++) begin
      wheel_tgt[i] = '0;
      enc_tgt[i] = '0;
    end
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_STEP_SIZE:          step_r  = d[9:0];
      REG_GEAR_RATIO:         gear_r  = d[7:0];
      REG_MAX_WHEEL_TARGET:   maxw_r  = d[15:0];
      REG_MAX_ENCODER_TARGET: maxe_r  = d[15:0];
      REG_MAX_DRIVE_Q16:      maxd_r  = d[17:0];
      REG_RPM_PER_HZ_Q8:      rphz_r  = d[15:0];
      REG_DUTY_SCALE:         scale_r = d[7:0];
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] rpm_of(input logic [31:0] p);
    longint unsigned q;
    if (p == '0) return '0;
    q = (64'(US_PER_S) * 64'(rphz_r)) / (64'(p) * 64'd256);
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic logic [15:0] capped_target(input longint unsigned w);
    longint unsigned e;
    e = w * gear_r;
    return (e > maxe_r) ? maxe_r : e[15:0];
  endfunction

  function automatic void controller_step(input func_t f, input logic [1:0] w,
                                          input logic [31:0] t, input logic s,
                                          input logic signed [7:0] amt,
                                          input logic [15:0] trpm);
    longint tgt, diff, err, lvl, wt;
    logic [15:0] rpm;
    wheel_report_t rep;
    case (f)
      FUNC_EDGE: begin
        if (w < WHEELS) begin
          period_q[w] = t - last_edge_q[w];
          last_edge_q[w] = t;
        end
      end
      FUNC_ADJUST: begin
        wt = longint'(wheel_tgt[s]) + longint'(step_r) * longint'(amt);
        if (wt < 0) wt = 0;
        if (wt > longint'(maxw_r)) wt = longint'(maxw_r);
        wheel_tgt[s] = wt[15:0];
        enc_tgt[s] = capped_target(wt);
      end
      FUNC_SET: enc_tgt[s] = capped_target(trpm);
      FUNC_TICK: begin
        for (int i = 0; i < TICK_RESULTS; i++) begin
          tgt = (i < 2) ? longint'(enc_tgt[SIDE_RIGHT]) : longint'(enc_tgt[SIDE_LEFT]);
          rpm = rpm_of(period_q[i]);
          if (tgt == 0) begin
            drive_q[i] = '0;
          end else begin
            diff = tgt - longint'(rpm);
            if (diff * 20 >= tgt) err = longint'(ERR_LIMIT_Q16);
            else if (-diff * 20 >= tgt) err = -longint'(ERR_LIMIT_Q16);
            else err = (diff * 65536) / tgt;
            lvl = longint'(drive_q[i]) + err;
            if (lvl < 0) lvl = 0;
            if (lvl > longint'(maxd_r)) lvl = longint'(maxd_r);
            drive_q[i] = lvl[17:0];
          end
          lvl = (longint'(drive_q[i]) * longint'(scale_r)) >>> 16;
          rep.out_wheel = 2'(i);
          rep.duty = (lvl > 255) ? 8'hFF : lvl[7:0];
          rep.measured_rpm = rpm;
          rep.last = (i == TICK_RESULTS - 1);
          if (on_wire.pinned) begin
            rep.duty = on_wire.pin_duty;
            rep.measured_rpm = on_wire.pin_rpm;
          end
          due_reports.push_back(rep);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void report_fault(input string what, input wheel_report_t want,
                                       input wheel_report_t got);
    faults++;
    if (faults <= MAX_SHOWN)
      $display("%0t %s: wheel %0d/%0d duty %0d/%0d rpm %0d/%0d last %0d/%0d (exp/act)",
               $time, what, want.out_wheel, got.out_wheel, want.duty, got.duty,
               want.measured_rpm, got.measured_rpm, want.last, got.last);
  endfunction

  always @(posedge clk) begin
    wheel_report_t got, want;
    if (rst) begin
      controller_reset();
    end else begin
      if (cfg_we) apply_reg(cfg_index, cfg_data);
      if (cmd.valid && cmd.ready)
        controller_step(func_t'(cmd.func), cmd.wheel, cmd.edge_time, cmd.side_sel,
                        cmd.amount, cmd.target_rpm);
      if (result.valid && result.ready) begin
        got = '{result.out_wheel, result.duty, result.measured_rpm, result.last};
        if (due_reports.size() == 0) begin
          want = '0;
          report_fault("unexpected transaction", want, got);
        end else begin
          want = due_reports.pop_front();
          if (got.out_wheel !== want.out_wheel || got.duty !== want.duty ||
              got.measured_rpm !== want.measured_rpm || got.last !== want.last)
            report_fault("mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) result.ready <= calm || ($urandom_range(99) >= 22);

  // period that lands near the wheel's encoder target, within a few percent
  function automatic logic [31:0] near_period(input logic [1:0] w);
    longint unsigned tgt, p;
    tgt = (w < 2) ? enc_tgt[SIDE_RIGHT] : enc_tgt[SIDE_LEFT];
    if (tgt == 0 || rphz_r == 0) return $urandom_range(1, 60000);
    p = (64'(US_PER_S) * rphz_r) / (tgt * 256);
    p = p + (p * $urandom_range(0, 8)) / 100 - (p * 4) / 100;
    if (p == 0) p = 1;
    return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  function automatic esc_cmd_t draw_cmd();
    esc_cmd_t c;
    int unsigned roll;
    c = '0;
    c.wheel = 2'($urandom_range(0, 3));
    c.side_sel = 1'($urandom_range(0, 1));
    c.amount = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                    : 8'(int'($urandom_range(0, 16)) - 8);
    c.target_rpm = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3000));
    if ($urandom_range(0, 9) == 0) c.target_rpm = '0;
    c.edge_time = $urandom;
    roll = $urandom_range(99);
    if (roll < 45) begin
      c.func = FUNC_EDGE;
      roll = $urandom_range(99);
      if (roll < 60) c.edge_time = last_edge_q[c.wheel] + near_period(c.wheel);
      else if (roll < 75) c.edge_time = last_edge_q[c.wheel] + $urandom_range(1, 100000);
      else if (roll < 85) c.edge_time = last_edge_q[c.wheel] + $urandom_range(0, 3);
    end else if (roll < 70) begin
      c.func = FUNC_TICK;
    end else if (roll < 85) begin
      c.func = FUNC_ADJUST;
    end else begin
      c.func = FUNC_SET;
    end
    return c;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] spill(input int unsigned val, input int w);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'($urandom);
    noise = (noise >> w) << w;
    return noise | CFG_DATA_W'(val);
  endfunction

  task automatic push_cmd(input esc_cmd_t c);
    while (!calm && $urandom_range(99) < 22) begin
      cmd.valid <= 1'b0;
      @(negedge clk);
    end
    cmd.valid      <= 1'b1;
    cmd.func       <= c.func;
    cmd.wheel      <= c.wheel;
    cmd.edge_time  <= c.edge_time;
    cmd.side_sel   <= c.side_sel;
    cmd.amount     <= c.amount;
    cmd.target_rpm <= c.target_rpm;
    on_wire        <= c;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_regs(input reg_set_t v);
    for (int k = 0; k <= REG_DUTY_SCALE; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(k);
      cfg_data  <= v[k];
      @(negedge clk);
    end
    cfg_we    <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_data  <= CFG_DATA_W'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    cmd.valid <= 1'b0;
    while (due_reports.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    esc_cmd_t script [20];
    reg_set_t regs;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    cmd.valid      = 1'b0;
    cmd.func       = FUNC_EDGE;
    cmd.wheel      = '0;
    cmd.edge_time  = '0;
    cmd.side_sel   = SIDE_LEFT;
    cmd.amount     = '0;
    cmd.target_rpm = '0;
    result.ready   = 1'b0;
    on_wire        = '0;

    // func, wheel, edge_time, side, amount, target, pinned, duty, rpm
    script = '{
      '{FUNC_TICK,   2'd0, 32'h0000_0000, SIDE_LEFT,  8'sd0,   16'd0,     1'b1, 8'd0, 16'd0},
      '{FUNC_EDGE,   2'd0, 32'hFFFF_FFFF, SIDE_LEFT,  8'sd0,   16'd0,     1'b0, 8'd0, 16'd0},
      '{FUNC_EDGE,   2'd0, 32'h0000_0000, SIDE_LEFT,  8'sd0,   16'd0,     1'b0, 8'd0, 16'd0},
      '{FUNC_EDGE,   2'd1, 32'h0000_0001, SIDE_LEFT,  8'sd0,   16'd0,     1'b0, 8'd0, 16'd0},
      '{FUNC_EDGE,   2'd2, 32'h0000_0001, SIDE_LEFT,  8'sd0,   16'd0,     1'b0, 8'd0, 16'd0},
      '{FUNC_EDGE,   2'd3, 32'h0000_0001, SIDE_LEFT,  8'sd0,   16'd0,     1'b0, 8'd0, 16'd0},
      '{FUNC_TICK,   2'd0, 32'h0000_0000, SIDE_LEFT,  8'sd0,   16'd0,     1'b1, 8'd0, 16'hFFFF},
      '{FUNC_ADJUST, 2'd0, 32'h0000_0000, SIDE_RIGHT, 8'sd127, 16'd0,     1'b0, 8'd0, 16'd0},
      '{FUNC_ADJUST, 2'd0, 32'h0000_0000, SIDE_LEFT,  8'sh80,  16'd0,     1'b0, 8'd0, 16'd0},
      '{FUNC_SET,    2'd0, 32'h0000_0000, SIDE_LEFT,  8'sd0,   16'hFFFF,  1'b0, 8'd0, 16'd0},
      '{FUNC_TICK,   2'd0, 32'h0000_0000, SIDE_LEFT,  8'sd0,   16'd0,     1'b0, 8'd0, 16'd0},
      '{FUNC_EDGE,   2'd1, 32'h8000_0001, SIDE_LEFT,  8'sd0,   16'd0,     1'b0, 8'd0, 16'd0},
      '{FUNC_EDGE,   2'd2, 32'h0000_03E9, SIDE_LEFT,  8'sd0,   16'd0,     1'b0, 8'd0, 16'd0},
      '{FUNC_EDGE,   2'd3, 32'hFFFF_FFFF, SIDE_LEFT,  8'sd0,   16'd0,     1'b0, 8'd0, 16'd0},
      '{FUNC_SET,    2'd0, 32'h0000_0000, SIDE_RIGHT, 8'sd0,   16'd0,     1'b0, 8'd0, 16'd0},
      '{FUNC_TICK,   2'd0, 32'h0000_0000, SIDE_LEFT,  8'sd0,   16'd0,     1'b0, 8'd0, 16'd0},
      '{FUNC_ADJUST, 2'd0, 32'h0000_0000, SIDE_RIGHT, 8'sd1,   16'd0,     1'b0, 8'd0, 16'd0},
      '{FUNC_EDGE,   2'd0, 32'h0000_0000, SIDE_LEFT,  8'sd0,   16'd0,     1'b0, 8'd0, 16'd0},
      '{FUNC_TICK,   2'd0, 32'h0000_0000, SIDE_LEFT,  8'sd0,   16'd0,     1'b0, 8'd0, 16'd0},
      '{FUNC_TICK,   2'd0, 32'h0000_0000, SIDE_LEFT,  8'sd0,   16'd0,     1'b0, 8'd0, 16'd0}
    };

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    foreach (script[r]) push_cmd(script[r]);
    settle();

    // min extremes, reset values (no idling), random, max extremes last
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          regs[REG_STEP_SIZE]          = '0;
          regs[REG_GEAR_RATIO]         = '0;
          regs[REG_MAX_WHEEL_TARGET]   = '0;
          regs[REG_MAX_ENCODER_TARGET] = '0;
          regs[REG_MAX_DRIVE_Q16]      = '0;
          regs[REG_RPM_PER_HZ_Q8]      = 18'd1;
          regs[REG_DUTY_SCALE]         = '0;
        end
        1: begin
          regs[REG_STEP_SIZE]          = RST_STEP_SIZE;
          regs[REG_GEAR_RATIO]         = RST_GEAR_RATIO;
          regs[REG_MAX_WHEEL_TARGET]   = RST_MAX_WHEEL_TARGET;
          regs[REG_MAX_ENCODER_TARGET] = RST_MAX_ENCODER_TARGET;
          regs[REG_MAX_DRIVE_Q16]      = RST_MAX_DRIVE_Q16;
          regs[REG_RPM_PER_HZ_Q8]      = RST_RPM_PER_HZ_Q8;
          regs[REG_DUTY_SCALE]         = RST_DUTY_SCALE;
        end
        PHASES - 1: begin
          regs[REG_STEP_SIZE]          = 18'd1023;
          regs[REG_GEAR_RATIO]         = 18'd255;
          regs[REG_MAX_WHEEL_TARGET]   = 18'd65535;
          regs[REG_MAX_ENCODER_TARGET] = 18'd65535;
          regs[REG_MAX_DRIVE_Q16]      = 18'd262143;
          regs[REG_RPM_PER_HZ_Q8]      = 18'd65535;
          regs[REG_DUTY_SCALE]         = 18'd255;
        end
        default: begin
          regs[REG_STEP_SIZE]          = spill($urandom_range(0, 1023), 10);
          regs[REG_GEAR_RATIO]         = spill($urandom_range(1, 12), 8);
          regs[REG_MAX_WHEEL_TARGET]   = spill($urandom_range(0, 65535), 16);
          regs[REG_MAX_ENCODER_TARGET] = spill($urandom_range(0, 65535), 16);
          regs[REG_MAX_DRIVE_Q16]      = spill($urandom_range(0, 262143), 18);
          regs[REG_RPM_PER_HZ_Q8]      = spill($urandom_range(1000, 40000), 16);
          regs[REG_DUTY_SCALE]         = spill($urandom_range(0, 255), 8);
        end
      endcase
      program_regs(regs);
      calm <= (ph == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) push_cmd(draw_cmd());
      settle();
    end

    if (faults == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

/* encoder_speed_controller.f */
+incdir+hdl
hdl/esc_pkg.sv
hdl/esc_if.sv
hdl/esc_ram.sv
hdl/esc_div.sv
hdl/encoder_speed_controller.sv
sim/encoder_speed_controller_tb.sv
